/* src/tmss_pkg.sv */
`timescale 1ns / 1ps
package tmss_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CUR_W = $clog2(MAX_SEGMENTS + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Opcodes of a request
  localparam logic [1:0] OP_TICK     = 2'd0;
  localparam logic [1:0] OP_LOAD     = 2'd1;
  localparam logic [1:0] OP_SET_STEP = 2'd2;
  localparam logic [1:0] OP_SET_RATE = 2'd3;

  // Run modes
  localparam logic [1:0] MODE_NOP = 2'd0;
  localparam logic [1:0] MODE_RUN = 2'd1;
  localparam logic [1:0] MODE_END = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_STEP      = 1'd1;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         segment_slot;
    logic [31:0]        seg_begin;
    logic [31:0]        seg_end;
    logic signed [15:0] seg_rate;
    logic [15:0]        seg_gain;
    logic [7:0]         seg_plastic;
    logic [9:0]         seg_stimulus;
    logic [31:0]        new_step;
    logic signed [15:0] new_rate;
  } req_t;

  typedef struct packed {
    logic [1:0]         run_mode;
    logic [31:0]        step_now;
    logic signed [15:0] rate_now;
    logic signed [15:0] rate_before;
    logic [15:0]        gain_now;
    logic [7:0]         plastic_now;
    logic [9:0]         stimulus_now;
  } res_t;

  typedef struct packed {
    logic [31:0]        seg_begin;
    logic [31:0]        seg_end;
    logic signed [15:0] rate;
    logic [15:0]        gain;
    logic [7:0]         plastic;
    logic [9:0]         stimulus;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_LOAD,
    CMD_SKIP,
    CMD_SET_STEP,
    CMD_SET_RATE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   slot;
    entry_t             entry;
    logic [31:0]        new_step;
    logic signed [15:0] new_rate;
  } cmd_t;

endpackage

/* src/timed_mode_schedule_sequencer_unit.sv */
`timescale 1ns / 1ps
// Load, set step, set rate and a tick past final_step go from idle straight to the reply
//   state; other ticks go through read and check, again for each segment stepped past.
// The back end takes no new request until its reply state registers the last result;
//   result stalls hold it there, and the two-entry front queue takes requests meanwhile.
// Reset (rst, synchronous): cursor 0, step 0, mode NOP, rates 0, gain 1, plastic 1,
//   stimulus 0, segments_in_use 1, final_step 0; table undefined until loaded.
module timed_mode_schedule_sequencer_unit (
  input  logic                               clk,
  input  logic                               rst,
  // request channel
  input  logic                               req_valid,
  output logic                               req_ready,
  input  tmss_pkg::req_t                     req,
  // result channel
  output logic                               res_valid,
  input  logic                               res_ready,
  output tmss_pkg::res_t                     res,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tmss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);

  tmss_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;
  logic [4:0]     segments_in_use;
  logic [31:0]    final_step;

  // Configuration must be written only while idle (the block does not enforce this), so always take it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments_in_use <= 5'd1;
      final_step      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tmss_pkg::CFG_SEGMENTS_IN_USE: segments_in_use <= cfg_data[4:0];
        tmss_pkg::CFG_FINAL_STEP:      final_step      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: accept each request, classify it and hold it in a short queue.
  tmss_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // Back: own the segment table and timeline state, walk the cursor, and
  // register one result per request behind its own valid/ready stage.
  tmss_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .segments_in_use (segments_in_use),
    .final_step      (final_step),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

endmodule

/* src/tmss_front.sv */
`timescale 1ns / 1ps
module tmss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  tmss_pkg::req_t      req,
  output tmss_pkg::cmd_t      cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready
);

  tmss_pkg::cmd_t                   queue [tmss_pkg::QUEUE_DEPTH];
  logic [tmss_pkg::QPTR_W-1:0]      wr_ptr;
  logic [tmss_pkg::QPTR_W-1:0]      rd_ptr;
  logic [tmss_pkg::QCNT_W-1:0]      count;
  tmss_pkg::cmd_t                   cls;
  logic                             push;
  logic                             pop;

  // Classify the request into a command for the back end
  always_comb begin
    cls.slot           = tmss_pkg::IDX_W'(req.segment_slot);
    cls.entry.seg_begin = req.seg_begin;
    cls.entry.seg_end  = req.seg_end;
    cls.entry.rate     = req.seg_rate;
    cls.entry.gain     = req.seg_gain;
    cls.entry.plastic  = req.seg_plastic;
    cls.entry.stimulus = req.seg_stimulus;
    cls.new_step       = req.new_step;
    cls.new_rate       = req.new_rate;
    case (req.opcode)
      tmss_pkg::OP_TICK:     cls.kind = tmss_pkg::CMD_TICK;
      tmss_pkg::OP_LOAD: begin
        // drop loads aimed past the table
        if (32'(req.segment_slot) < tmss_pkg::MAX_SEGMENTS) cls.kind = tmss_pkg::CMD_LOAD;
        else cls.kind = tmss_pkg::CMD_SKIP;
      end
      tmss_pkg::OP_SET_STEP: cls.kind = tmss_pkg::CMD_SET_STEP;
      tmss_pkg::OP_SET_RATE: cls.kind = tmss_pkg::CMD_SET_RATE;
      default:               cls.kind = tmss_pkg::CMD_SKIP;
    endcase
  end

  assign req_ready = (32'(count) < tmss_pkg::QUEUE_DEPTH);
  assign cmd_valid = (count != '0);
  assign cmd       = queue[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == tmss_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == tmss_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/tmss_back.sv */
`timescale 1ns / 1ps
module tmss_back (
  input  logic                clk,
  input  logic                rst,
  input  tmss_pkg::cmd_t      cmd,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  logic [4:0]          segments_in_use,
  input  logic [31:0]         final_step,
  output logic                res_valid,
  input  logic                res_ready,
  output tmss_pkg::res_t      res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_REPLY
  } state_t;

  state_t                          state;
  tmss_pkg::entry_t                table_mem [tmss_pkg::MAX_SEGMENTS];
  tmss_pkg::entry_t                rd_entry;
  logic [tmss_pkg::CUR_W-1:0]      cursor;
  logic [tmss_pkg::CUR_W-1:0]      limit;
  logic [31:0]                     step_count;
  logic [31:0]                     step_next;
  logic [1:0]                      mode;
  logic signed [15:0]              rate;
  logic signed [15:0]              rate_old;
  logic [15:0]                     gain;
  logic [7:0]                      plastic;
  logic [9:0]                      stimulus;
  logic                            table_we;

  assign cmd_ready = (state == S_IDLE);
  assign step_next = step_count + 32'd1;
  assign table_we  = (state == S_IDLE) && cmd_valid && (cmd.kind == tmss_pkg::CMD_LOAD);

  // Saturate the scan count to the table depth
  always_comb begin
    if (32'(segments_in_use) > tmss_pkg::MAX_SEGMENTS) begin
      limit = tmss_pkg::CUR_W'(tmss_pkg::MAX_SEGMENTS);
    end else begin
      limit = tmss_pkg::CUR_W'(segments_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (table_we) begin
      table_mem[cmd.slot] <= cmd.entry;
    end
    rd_entry <= table_mem[cursor[tmss_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cursor     <= '0;
      step_count <= '0;
      mode       <= tmss_pkg::MODE_NOP;
      rate       <= '0;
      rate_old   <= '0;
      gain       <= 16'd1;
      plastic    <= 8'd1;
      stimulus   <= '0;
      res_valid  <= 1'b0;
    end else begin
      if (res_valid && res_ready && (state != S_REPLY)) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_REPLY;
            case (cmd.kind)
              tmss_pkg::CMD_TICK: begin
                step_count <= step_next;
                if (step_next > final_step) begin
                  mode <= tmss_pkg::MODE_END;
                end else begin
                  state <= S_READ;
                end
              end
              tmss_pkg::CMD_SET_STEP: step_count <= cmd.new_step;
              tmss_pkg::CMD_SET_RATE: rate <= cmd.new_rate;
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          state <= S_REPLY;
          if (cursor < limit) begin
            if (step_count > rd_entry.seg_begin && step_count <= rd_entry.seg_end) begin
              rate_old <= rate;
              rate     <= rd_entry.rate;
              gain     <= rd_entry.gain;
              plastic  <= rd_entry.plastic;
              stimulus <= rd_entry.stimulus;
              mode     <= tmss_pkg::MODE_RUN;
            end else if (step_count < rd_entry.seg_begin) begin
              mode <= tmss_pkg::MODE_NOP;
            end else begin
              // segment over or starts at this step: advance and read again
              cursor <= cursor + 1'b1;
              state  <= S_READ;
            end
          end
        end
        S_REPLY: begin
          if (!res_valid || res_ready) begin
            res_valid        <= 1'b1;
            res.run_mode     <= mode;
            res.step_now     <= step_count;
            res.rate_now     <= rate;
            res.rate_before  <= rate_old;
            res.gain_now     <= gain;
            res.plastic_now  <= plastic;
            res.stimulus_now <= stimulus;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int PRINT_CAP    = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           req_valid = 1'b0;
  logic                           req_ready;
  tmss_pkg::req_t                 req = '0;
  logic                           res_valid;
  logic                           res_ready = 1'b0;
  tmss_pkg::res_t                 res;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [tmss_pkg::CFG_IDX_W-1:0] cfg_index = tmss_pkg::CFG_SEGMENTS_IN_USE;
  logic [31:0]                    cfg_data = '0;

  timed_mode_schedule_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the sequencer: segment table, cursor, step count, mode and the
  // active settings, plus the two configuration registers.
  // ---------------------------------------------------------------------------
  tmss_pkg::entry_t   tl_segs [0:tmss_pkg::MAX_SEGMENTS-1];
  int                 tl_cursor = 0;
  logic [31:0]        tl_step = '0;
  logic [1:0]         tl_mode = tmss_pkg::MODE_NOP;
  logic signed [15:0] tl_rate = '0;
  logic signed [15:0] tl_rate_old = '0;
  logic [15:0]        tl_gain = 16'd1;
  logic [7:0]         tl_plastic = 8'd1;
  logic [9:0]         tl_stim = '0;
  logic [4:0]         tl_seg_limit = 5'd1;
  logic [31:0]        tl_last_step = '0;

  // Pending requests for the driver, and statuses still owed by the block
  tmss_pkg::req_t request_q [$];
  tmss_pkg::res_t status_expected_q [$];

  int mismatch_count = 0;
  int checked_count = 0;
  int run_seen = 0;
  int nop_seen = 0;
  int end_seen = 0;
  int cycle_count = 0;

  // Append to the tail of the pending and expected queues
  function automatic void add_request(input tmss_pkg::req_t r);
    request_q.insert(request_q.size(), r);
  endfunction

  function automatic void add_expected(input tmss_pkg::res_t s);
    status_expected_q.insert(status_expected_q.size(), s);
  endfunction

  // Apply one request to the shadow state and return the status it must produce.
  function automatic tmss_pkg::res_t predict_status(input tmss_pkg::req_t r);
    tmss_pkg::res_t   s;
    tmss_pkg::entry_t e;
    int               lim;
    bit               done;
    case (r.opcode)
      tmss_pkg::OP_TICK: begin
        tl_step = tl_step + 32'd1;
        if (tl_step > tl_last_step) begin
          tl_mode = tmss_pkg::MODE_END;
        end else begin
          // Saturate the scan to the table size; walk past finished segments and
          // past a segment whose begin equals the step.
          lim = (tl_seg_limit > tmss_pkg::MAX_SEGMENTS) ? tmss_pkg::MAX_SEGMENTS
                                                        : int'(tl_seg_limit);
          done = 1'b0;
          while (!done && tl_cursor < lim) begin
            e = tl_segs[tl_cursor];
            if (tl_step > e.seg_begin && tl_step <= e.seg_end) begin
              tl_rate_old = tl_rate;
              tl_rate = e.rate;
              tl_gain = e.gain;
              tl_plastic = e.plastic;
              tl_stim = e.stimulus;
              tl_mode = tmss_pkg::MODE_RUN;
              done = 1'b1;
            end else if (tl_step < e.seg_begin) begin
              tl_mode = tmss_pkg::MODE_NOP;
              done = 1'b1;
            end else begin
              tl_cursor++;
            end
          end
        end
      end
      tmss_pkg::OP_LOAD: begin
        tl_segs[r.segment_slot] = '{seg_begin: r.seg_begin, seg_end: r.seg_end,
                                    rate: r.seg_rate, gain: r.seg_gain,
                                    plastic: r.seg_plastic, stimulus: r.seg_stimulus};
      end
      tmss_pkg::OP_SET_STEP: tl_step = r.new_step;
      default:               tl_rate = r.new_rate;
    endcase
    s.run_mode = tl_mode;
    s.step_now = tl_step;
    s.rate_now = tl_rate;
    s.rate_before = tl_rate_old;
    s.gain_now = tl_gain;
    s.plastic_now = tl_plastic;
    s.stimulus_now = tl_stim;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  // Fill every field at random so that unused fields toggle too.
  function automatic tmss_pkg::req_t random_request();
    tmss_pkg::req_t r;
    r.opcode = 2'($urandom_range(0, 3));
    r.segment_slot = 4'($urandom_range(0, 15));
    r.seg_begin = $urandom;
    r.seg_end = $urandom;
    r.seg_rate = 16'($urandom);
    r.seg_gain = 16'($urandom);
    r.seg_plastic = 8'($urandom);
    r.seg_stimulus = 10'($urandom);
    r.new_step = $urandom;
    r.new_rate = 16'($urandom);
    return r;
  endfunction

  function automatic tmss_pkg::req_t op_req(input logic [1:0] op, input logic [31:0] val);
    tmss_pkg::req_t r;
    r = random_request();
    r.opcode = op;
    if (op == tmss_pkg::OP_SET_STEP) r.new_step = val;
    if (op == tmss_pkg::OP_SET_RATE) r.new_rate = val[15:0];
    return r;
  endfunction

  function automatic tmss_pkg::req_t load_req(input logic [3:0] slot,
                                              input logic [31:0] lo,
                                              input logic [31:0] hi,
                                              input logic [15:0] rate,
                                              input logic [15:0] gain,
                                              input logic [7:0] plastic,
                                              input logic [9:0] stim);
    tmss_pkg::req_t r;
    r = random_request();
    r.opcode = tmss_pkg::OP_LOAD;
    r.segment_slot = slot;
    r.seg_begin = lo;
    r.seg_end = hi;
    r.seg_rate = rate;
    r.seg_gain = gain;
    r.seg_plastic = plastic;
    r.seg_stimulus = stim;
    return r;
  endfunction

  // Hold until every request has gone in and every status has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (request_q.size() != 0 || req_valid || status_expected_q.size() != 0)
      @(negedge clk);
  endtask

  // Write one register; the block is idle whenever this is called.
  task automatic write_reg(input logic [tmss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == tmss_pkg::CFG_SEGMENTS_IN_USE) tl_seg_limit = data[4:0];
    else tl_last_step = data;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: send requests from the pending queue in bursts with random gaps.
  // Predict each request at the edge that accepts it.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;
  bit req_busy;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      req_busy = req_valid;
      if (req_valid && req_ready) begin
        add_expected(predict_status(req));
        req_busy = 1'b0;
      end
      if (!req_busy) begin
        if (gap_left > 0) begin
          gap_left--;
          req_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          req <= request_q.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Start a new burst; a quarter of them follow with no gap at all
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall the result side on a 32-bit pattern that changes each window,
  // and check every accepted status against the oldest expectation.
  // ---------------------------------------------------------------------------
  logic [31:0]    stall_pat = '1;
  int             stall_pos = 0;
  tmss_pkg::res_t want;

  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      stall_pos = 0;
    end else begin
      if (res_valid && res_ready) begin
        if (status_expected_q.size() == 0) begin
          report_mismatch("unexpected status, step", res.step_now, '0);
        end else begin
          want = status_expected_q.pop_front();
          checked_count++;
          case (want.run_mode)
            tmss_pkg::MODE_RUN: run_seen++;
            tmss_pkg::MODE_END: end_seen++;
            default:            nop_seen++;
          endcase
          if (res.run_mode !== want.run_mode)
            report_mismatch("run_mode", 32'(res.run_mode), 32'(want.run_mode));
          if (res.step_now !== want.step_now)
            report_mismatch("step_now", res.step_now, want.step_now);
          if (res.rate_now !== want.rate_now)
            report_mismatch("rate_now", 32'(res.rate_now), 32'(want.rate_now));
          if (res.rate_before !== want.rate_before)
            report_mismatch("rate_before", 32'(res.rate_before), 32'(want.rate_before));
          if (res.gain_now !== want.gain_now)
            report_mismatch("gain_now", 32'(res.gain_now), 32'(want.gain_now));
          if (res.plastic_now !== want.plastic_now)
            report_mismatch("plastic_now", 32'(res.plastic_now), 32'(want.plastic_now));
          if (res.stimulus_now !== want.stimulus_now)
            report_mismatch("stimulus_now", 32'(res.stimulus_now),
                            32'(want.stimulus_now));
        end
      end
      if (stall_pos == 0) begin
        // Pick the next window: no stalls, random, light or heavy stalling
        case ($urandom_range(0, 3))
          0:       stall_pat = '1;
          1:       stall_pat = $urandom;
          2:       stall_pat = $urandom | $urandom;
          default: stall_pat = $urandom & $urandom;
        endcase
      end
      res_ready <= stall_pat[stall_pos];
      stall_pos = (stall_pos + 1) % 32;
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: a directed opening, then random phases. Each phase waits for the
  // block to drain, rewrites both registers and queues up to three fresh schedule windows
  // at the cursor followed by mostly ticks.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int             random_items;
    int             directed_items;
    int             phases;
    int             n;
    int             sel;
    int             lim;
    logic [31:0]    base;
    logic [31:0]    lo;
    logic [31:0]    hi;
    logic [31:0]    last_step;
    tmss_pkg::req_t r;

    random_items = 0;
    phases = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Load the whole table so that no scan ever reads an empty slot. Slot 0
    // carries the top field values, slot 3 the bottom ones at the step ceiling.
    add_request(load_req(4'd0, 32'd0, 32'd3, 16'h7FFF, 16'hFFFF, 8'hFF, 10'h3FF));
    add_request(load_req(4'd1, 32'd5, 32'd8, 16'h0100, 16'h00FF, 8'h0F, 10'h155));
    add_request(load_req(4'd2, 32'd20, 32'd30, 16'hFF00, 16'h5A5A, 8'hA5, 10'h2AA));
    add_request(load_req(4'd3, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'h8000, 16'h0000,
                         8'h00, 10'h000));
    for (int s = 4; s < tmss_pkg::MAX_SEGMENTS; s++) begin
      r = random_request();
      r.opcode = tmss_pkg::OP_LOAD;
      r.segment_slot = 4'(s);
      add_request(r);
    end
    // With the reset registers the first tick is already past the final step
    add_request(op_req(tmss_pkg::OP_TICK, '0));
    directed_items = request_q.size();
    wait_drained();

    // No segments scanned: the mode is kept
    write_reg(tmss_pkg::CFG_SEGMENTS_IN_USE, 32'd0);
    write_reg(tmss_pkg::CFG_FINAL_STEP, 32'hFFFF_FFFF);
    add_request(op_req(tmss_pkg::OP_SET_STEP, 32'd0));
    add_request(op_req(tmss_pkg::OP_TICK, '0));
    directed_items += 2;
    wait_drained();

    // Count above the table size saturates. Run slot 0, override the rate,
    // leave it, hit slot 1 exactly at its begin, then jump to the ceiling,
    // enter slot 3 and wrap the step count.
    write_reg(tmss_pkg::CFG_SEGMENTS_IN_USE, 32'd31);
    add_request(op_req(tmss_pkg::OP_SET_STEP, 32'd0));
    add_request(op_req(tmss_pkg::OP_TICK, '0));
    add_request(op_req(tmss_pkg::OP_SET_RATE, 32'h8000));
    repeat (4) add_request(op_req(tmss_pkg::OP_TICK, '0));
    add_request(op_req(tmss_pkg::OP_SET_STEP, 32'hFFFF_FFFE));
    add_request(op_req(tmss_pkg::OP_TICK, '0));
    add_request(op_req(tmss_pkg::OP_TICK, '0));
    add_request(op_req(tmss_pkg::OP_SET_RATE, 32'h7FFF));
    directed_items += 11;

    while (random_items < RANDOM_ITEMS) begin
      // Every phase begins idle, which also makes the sender wait for all results
      wait_drained();
      phases++;
      base = tl_step;

      sel = $urandom_range(0, 9);
      if (sel == 0) lim = 0;
      else if (sel == 1) lim = $urandom_range(17, 31);
      else if (sel == 2) lim = $urandom_range(0, tl_cursor);
      else lim = (tl_cursor + 3 > tmss_pkg::MAX_SEGMENTS) ? tmss_pkg::MAX_SEGMENTS
                                                          : tl_cursor + $urandom_range(1, 3);
      sel = $urandom_range(0, 9);
      if (sel == 0) last_step = base + $urandom_range(0, 15);
      else if (sel == 1) last_step = $urandom;
      else if (sel == 2) last_step = 32'hFFFF_FFFF;
      else if (sel == 3) last_step = 32'd0;
      else last_step = base + 32'd1000;
      if ($urandom_range(0, 1) == 0) begin
        write_reg(tmss_pkg::CFG_SEGMENTS_IN_USE, 32'(lim));
        write_reg(tmss_pkg::CFG_FINAL_STEP, last_step);
      end else begin
        write_reg(tmss_pkg::CFG_FINAL_STEP, last_step);
        write_reg(tmss_pkg::CFG_SEGMENTS_IN_USE, 32'(lim));
      end

      // Now and then move up to the ceiling so the step count wraps
      if ($urandom_range(0, 7) == 0) begin
        base = 32'hFFFF_FFF0 + $urandom_range(0, 8);
        add_request(op_req(tmss_pkg::OP_SET_STEP, base));
      end

      // Lay a short run of back-to-back windows from the cursor on
      lo = base + $urandom_range(0, 6);
      for (int s = tl_cursor; s < tmss_pkg::MAX_SEGMENTS && s < tl_cursor + 3; s++) begin
        hi = lo + $urandom_range(0, 30);
        add_request(load_req(4'(s), lo, hi, 16'($urandom), 16'($urandom),
                             8'($urandom), 10'($urandom)));
        lo = hi + $urandom_range(0, 5);
      end

      n = $urandom_range(18, 32);
      repeat (n) begin
        sel = $urandom_range(0, 99);
        if (sel < 72) begin
          r = op_req(tmss_pkg::OP_TICK, '0);
        end else if (sel < 80) begin
          r = op_req(tmss_pkg::OP_SET_STEP,
                     ($urandom_range(0, 5) == 0) ? $urandom : base + $urandom_range(0, 40));
        end else if (sel < 88) begin
          r = op_req(tmss_pkg::OP_SET_RATE, $urandom);
        end else begin
          r = random_request();
          r.opcode = tmss_pkg::OP_LOAD;
        end
        add_request(r);
      end
      random_items += request_q.size();
    end

    // Drain, then give the back end time to show any stray result
    wait_drained();
    repeat (100) @(posedge clk);
    @(negedge clk);
    if (status_expected_q.size() != 0)
      report_mismatch("statuses never returned", status_expected_q.size(), '0);

    $display("Checked %0d statuses: %0d directed and %0d random requests in %0d phases",
             checked_count, directed_items, random_items, phases);
    $display("Modes seen: run %0d, nop %0d, end %0d; cursor finished at segment %0d",
             run_seen, nop_seen, end_seen, tl_cursor);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
